@@ rtl/lud_pkg.sv @@
// Shared types, constants and helpers for the LU determinant block.
`timescale 1ns / 1ps

package lud_pkg;

    // Floating-point unit operation codes
    typedef enum logic [1:0] {
        FP_MUL,
        FP_SUB,
        FP_DIV
    } fp_op_t;

    // Request into the shared floating-point unit
    typedef struct packed {
        logic        start;
        fp_op_t      op;
        logic [31:0] a;
        logic [31:0] b;
    } fpu_req_t;

    // Status and result out of the shared floating-point unit
    typedef struct packed {
        logic        idle;
        logic        done;
        logic [31:0] result;
    } fpu_rsp_t;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;

    // Configuration register map (register index is paddr[2])
    localparam int          CFG_ADDR_W = 3;
    localparam logic        REG_MATRIX_SIZE = 1'b0;
    localparam logic [3:0]  MATRIX_SIZE_RESET = 4'd2;

    function automatic logic fp_is_nan(input logic [31:0] x);
        return (x[30:23] == EXP_ALL_ONES) && (x[22:0] != 23'd0);
    endfunction

endpackage

@@ rtl/lud_elem_if.sv @@
// Input channel: one matrix element per transaction.
`timescale 1ns / 1ps

interface lud_elem_if;
    logic        valid;
    logic        ready;
    logic [31:0] matrix_element;

    modport source (output valid, output matrix_element, input ready);
    modport sink (input valid, input matrix_element, output ready);
endinterface

@@ rtl/lud_det_if.sv @@
// Output channel: one determinant per transaction.
`timescale 1ns / 1ps

interface lud_det_if;
    logic        valid;
    logic        ready;
    logic [31:0] determinant;

    modport source (output valid, output determinant, input ready);
    modport sink (input valid, input determinant, output ready);
endinterface

@@ rtl/lud_fpu.sv @@
// Shared single-precision multiply / subtract / divide unit, round to nearest even.
`timescale 1ns / 1ps

module lud_fpu
(
    input  logic              clk,
    input  logic              rst_n,
    input  lud_pkg::fpu_req_t req,
    output lud_pkg::fpu_rsp_t rsp
);

    // Working mantissa: bit 48 is the units bit, bit 49 catches a carry
    localparam int XW = 50;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_NORM,
        F_RND
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic               done_reg, done_next;
    logic [31:0]        res_reg, res_next;

    logic [XW-1:0]      x_reg, x_next;
    logic signed [11:0] e_reg, e_next;
    logic               s_reg, s_next;
    logic [25:0]        q_reg, q_next;
    logic [25:0]        rem_reg, rem_next;
    logic [23:0]        dvs_reg, dvs_next;
    logic [4:0]         cnt_reg, cnt_next;

    function automatic logic [5:0] lzc50(input logic [XW-1:0] x);
        logic [5:0] n;
        logic       found;
        n = 6'd50;
        found = 1'b0;
        for (int b = XW - 1; b >= 0; b--) begin
            if (!found && x[b]) begin
                n = 6'(XW - 1 - b);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc24(input logic [23:0] x);
        logic [4:0] n;
        logic       found;
        n = 5'd24;
        found = 1'b0;
        for (int b = 23; b >= 0; b--) begin
            if (!found && x[b]) begin
                n = 5'(23 - b);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Right shift that folds every lost bit into bit 0
    function automatic logic [XW-1:0] shr_sticky(input logic [XW-1:0] x, input logic [7:0] amt);
        logic [XW-1:0] mask;
        mask = ~({XW{1'b1}} << amt);
        return (x >> amt) | {{(XW-1){1'b0}}, |(x & mask)};
    endfunction

    // Operand unpacking
    logic [7:0]         ea, eb, ea_eff, eb_eff;
    logic [23:0]        sig_a, sig_b;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic               sb_eff, sx;
    logic               spec;
    logic [31:0]        spec_res;

    // Subtract path
    logic               a_big, eff_sub, s_big;
    logic [23:0]        sig_big, sig_small;
    logic [7:0]         e_big, e_small, e_diff;
    logic [XW-1:0]      xb, xs, sum;

    // Divide path
    logic [4:0]         lza, lzb;
    logic [23:0]        na, nb;
    logic               q_ge;
    logic [25:0]        q_diff;

    // Multiply path
    logic [47:0]        prod;

    // Normalize
    logic [5:0]         lz;
    logic signed [11:0] sh, e_try, sh_f, e_f, neg_sh;
    logic [7:0]         rs;
    logic [XW-1:0]      y_norm;

    // Round
    logic [23:0]        mant, mant_r;
    logic               g_bit, st_bit, inc;
    logic [24:0]        m25;
    logic signed [11:0] e_r;
    logic [31:0]        rnd_res;

    always_comb
    begin
        ea = req.a[30:23];
        eb = req.b[30:23];
        ea_eff = (ea == 8'd0) ? 8'd1 : ea;
        eb_eff = (eb == 8'd0) ? 8'd1 : eb;
        sig_a = {ea != 8'd0, req.a[22:0]};
        sig_b = {eb != 8'd0, req.b[22:0]};
        a_nan = lud_pkg::fp_is_nan(req.a);
        b_nan = lud_pkg::fp_is_nan(req.b);
        a_inf = (ea == lud_pkg::EXP_ALL_ONES) && (req.a[22:0] == 23'd0);
        b_inf = (eb == lud_pkg::EXP_ALL_ONES) && (req.b[22:0] == 23'd0);
        a_zero = (req.a[30:0] == 31'd0);
        b_zero = (req.b[30:0] == 31'd0);
        sb_eff = (req.op == lud_pkg::FP_SUB) ? ~req.b[31] : req.b[31];
        sx = req.a[31] ^ req.b[31];

        // NaN and infinity operands, and zero operands of a multiply or divide, bypass the datapath
        spec = 1'b0;
        spec_res = lud_pkg::CANON_NAN;
        case (req.op)
            lud_pkg::FP_MUL:
            begin
                if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
                    spec = 1'b1;
                end else if (a_inf || b_inf) begin
                    spec = 1'b1;
                    spec_res = {sx, lud_pkg::EXP_ALL_ONES, 23'd0};
                end else if (a_zero || b_zero) begin
                    spec = 1'b1;
                    spec_res = {sx, 31'd0};
                end
            end
            lud_pkg::FP_SUB:
            begin
                if (a_nan || b_nan || (a_inf && b_inf && (req.a[31] != sb_eff))) begin
                    spec = 1'b1;
                end else if (a_inf) begin
                    spec = 1'b1;
                    spec_res = {req.a[31], lud_pkg::EXP_ALL_ONES, 23'd0};
                end else if (b_inf) begin
                    spec = 1'b1;
                    spec_res = {sb_eff, lud_pkg::EXP_ALL_ONES, 23'd0};
                end
            end
            lud_pkg::FP_DIV:
            begin
                if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                    spec = 1'b1;
                end else if (a_inf || b_zero) begin
                    spec = 1'b1;
                    spec_res = {sx, lud_pkg::EXP_ALL_ONES, 23'd0};
                end else if (a_zero || b_inf) begin
                    spec = 1'b1;
                    spec_res = {sx, 31'd0};
                end
            end
            default:
            begin
                spec = 1'b1;
            end
        endcase

        // Multiply
        prod = sig_a * sig_b;

        // Align and add/subtract magnitudes
        a_big = (req.a[30:0] >= req.b[30:0]);
        sig_big = a_big ? sig_a : sig_b;
        sig_small = a_big ? sig_b : sig_a;
        e_big = a_big ? ea_eff : eb_eff;
        e_small = a_big ? eb_eff : ea_eff;
        s_big = a_big ? req.a[31] : sb_eff;
        e_diff = e_big - e_small;
        eff_sub = req.a[31] ^ sb_eff;
        xb = {1'b0, sig_big, 25'd0};
        xs = shr_sticky({1'b0, sig_small, 25'd0}, e_diff);
        sum = eff_sub ? (xb - xs) : (xb + xs);

        // Divider operand pre-normalization
        lza = lzc24(sig_a);
        lzb = lzc24(sig_b);
        na = sig_a << lza;
        nb = sig_b << lzb;

        // One restoring quotient bit
        q_ge = (rem_reg >= {2'b00, dvs_reg});
        q_diff = q_ge ? (rem_reg - {2'b00, dvs_reg}) : rem_reg;

        // Normalize, clamped at the subnormal boundary
        lz = lzc50(x_reg);
        sh = x_reg[XW-1] ? -12'sd1 : ($signed({6'd0, lz}) - 12'sd1);
        e_try = e_reg - sh;
        sh_f = (e_try < 12'sd1) ? (e_reg - 12'sd1) : sh;
        e_f = e_reg - sh_f;
        neg_sh = -sh_f;
        rs = (neg_sh > 12'sd255) ? 8'd255 : neg_sh[7:0];
        y_norm = (sh_f >= 12'sd0) ? (x_reg << sh_f[5:0]) : shr_sticky(x_reg, rs);

        // Round to nearest even and pack
        mant = x_reg[48:25];
        g_bit = x_reg[24];
        st_bit = |x_reg[23:0];
        inc = g_bit & (st_bit | mant[0]);
        m25 = {1'b0, mant} + {24'd0, inc};
        e_r = e_reg + $signed({11'd0, m25[24]});
        mant_r = m25[24] ? m25[24:1] : m25[23:0];
        if (x_reg == '0) begin
            rnd_res = {s_reg, 31'd0};
        end else if (e_r >= 12'sd255) begin
            rnd_res = {s_reg, lud_pkg::EXP_ALL_ONES, 23'd0};
        end else begin
            rnd_res = {s_reg, (mant_r[23] ? e_r[7:0] : 8'd0), mant_r[22:0]};
        end
    end

    // Sequencing
    always_comb
    begin
        state_next = state_reg;
        done_next = 1'b0;
        res_next = res_reg;
        x_next = x_reg;
        e_next = e_reg;
        s_next = s_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (req.start) begin
                    if (spec) begin
                        res_next = spec_res;
                        done_next = 1'b1;
                    end else begin
                        case (req.op)
                            lud_pkg::FP_MUL:
                            begin
                                x_next = {prod, 2'b00};
                                e_next = $signed({4'd0, ea_eff}) + $signed({4'd0, eb_eff})
                                         - 12'sd127;
                                s_next = sx;
                                state_next = F_NORM;
                            end
                            lud_pkg::FP_SUB:
                            begin
                                x_next = sum;
                                e_next = $signed({4'd0, e_big});
                                s_next = (sum == '0) ? (req.a[31] & sb_eff) : s_big;
                                state_next = F_NORM;
                            end
                            default:
                            begin
                                rem_next = {2'b00, na};
                                dvs_next = nb;
                                q_next = '0;
                                cnt_next = 5'd25;
                                e_next = ($signed({4'd0, ea_eff}) - $signed({7'd0, lza}))
                                         - ($signed({4'd0, eb_eff}) - $signed({7'd0, lzb}))
                                         + 12'sd127;
                                s_next = sx;
                                state_next = F_DIV;
                            end
                        endcase
                    end
                end
            end
            F_DIV:
            begin
                q_next = {q_reg[24:0], q_ge};
                rem_next = {q_diff[24:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    x_next = {1'b0, q_reg[24:0], q_ge, 22'd0, q_diff != 26'd0};
                    state_next = F_NORM;
                end
            end
            F_NORM:
            begin
                x_next = y_norm;
                e_next = e_f;
                state_next = F_RND;
            end
            F_RND:
            begin
                res_next = rnd_res;
                done_next = 1'b1;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= F_IDLE;
            done_reg <= 1'b0;
            res_reg <= '0;
        end else begin
            state_reg <= state_next;
            done_reg <= done_next;
            res_reg <= res_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        e_reg <= e_next;
        s_reg <= s_next;
        q_reg <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.idle = (state_reg == F_IDLE);
    assign rsp.done = done_reg;
    assign rsp.result = res_reg;

endmodule

@@ rtl/lu_determinant.sv @@
// Top level: matrix store, elimination sequencer and configuration port.
`timescale 1ns / 1ps

// Loads an m-by-m single-precision matrix, one element per transaction in
// row-major order (m from matrix_size, 0 read as 1, clamped to MAX_DIM),
// then runs Doolittle elimination without pivoting and returns the product
// of the diagonal of U as one transaction; NaN results come out as 0x7FC00000.
// Elements are taken one per cycle while loading; a write of matrix_size
// drops a partly loaded matrix. After the last element the block takes no
// input until the result is handed to the output register. Compute time is
// set by one shared floating-point unit and the matrix memory's one read
// port: per multiplier two reads, start, 26 divide steps, normalize, round
// and hand-back; per updated entry two reads, multiply, subtract, write
// back; per diagonal product a read and a multiply. Special operands bypass
// the floating-point datapath.
module lu_determinant
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lud_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    lud_elem_if.sink                       elements,
    lud_det_if.source                      results
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW = $clog2(DEPTH);
    localparam int MW = $clog2(MAX_DIM + 1);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = 2 * MW + 1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_P_RD,
        S_S_RD,
        S_DIV,
        S_DIV_WAIT,
        S_K_RD,
        S_I_RD,
        S_MUL,
        S_MUL_WAIT,
        S_SUB_WAIT,
        S_D_RD0,
        S_D_FIRST,
        S_D_RD,
        S_D_MUL,
        S_D_WAIT,
        S_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [3:0]      matrix_size_reg, matrix_size_next;
    logic [CW-1:0]   load_count_reg, load_count_next;
    logic [MW-1:0]   k_reg, k_next;
    logic [MW-1:0]   i_reg, i_next;
    logic [MW-1:0]   j_reg, j_next;
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     det_out_reg, det_out_next;

    logic [31:0]     piv_reg, piv_next;
    logic [31:0]     l_reg, l_next;
    logic [31:0]     ukj_reg, ukj_next;
    logic [31:0]     uij_reg, uij_next;
    logic [31:0]     det_reg, det_next;

    // Matrix store
    logic [31:0]     mem [DEPTH];
    logic [31:0]     rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [31:0]     mem_wdata;

    logic [MW-1:0]   m_eff;
    logic [CW-1:0]   total;
    logic            in_fire, cfg_wr, last_elem;

    lud_pkg::fpu_req_t fpu_req;
    lud_pkg::fpu_rsp_t fpu_rsp;

    function automatic logic [AW-1:0] idx(input logic [MW-1:0] r, input logic [MW-1:0] c,
                                          input logic [MW-1:0] m);
        logic [PW-1:0] t;
        t = PW'(r) * PW'(m) + PW'(c);
        return t[AW-1:0];
    endfunction

    lud_fpu u_fpu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .rsp   (fpu_rsp)
    );

    // Effective matrix order and element count
    always_comb
    begin
        if (matrix_size_reg == 4'd0) begin
            m_eff = MW'(1);
        end else if (int'(matrix_size_reg) > MAX_DIM) begin
            m_eff = MW'(MAX_DIM);
        end else begin
            m_eff = MW'(matrix_size_reg);
        end
        total = CW'(PW'(m_eff) * PW'(m_eff));
    end

    // APB configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == lud_pkg::REG_MATRIX_SIZE) ? {28'd0, matrix_size_reg} : 32'd0;

    assign elements.ready = (state_reg == S_LOAD);
    assign in_fire = elements.valid && elements.ready;
    assign last_elem = (load_count_reg == total - CW'(1));
    assign results.valid = out_valid_reg;
    assign results.determinant = det_out_reg;

    // Elimination sequencer
    always_comb
    begin
        state_next = state_reg;
        matrix_size_next = matrix_size_reg;
        load_count_next = load_count_reg;
        k_next = k_reg;
        i_next = i_reg;
        j_next = j_reg;
        out_valid_next = out_valid_reg;
        det_out_next = det_out_reg;
        piv_next = piv_reg;
        l_next = l_reg;
        ukj_next = ukj_reg;
        uij_next = uij_reg;
        det_next = det_reg;
        mem_we = 1'b0;
        mem_waddr = load_count_reg[AW-1:0];
        mem_wdata = elements.matrix_element;
        mem_raddr = '0;
        fpu_req.start = 1'b0;
        fpu_req.op = lud_pkg::FP_MUL;
        fpu_req.a = ukj_reg;
        fpu_req.b = l_reg;

        if (results.ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire) begin
                    mem_we = 1'b1;
                    if (last_elem) begin
                        load_count_next = '0;
                        k_next = '0;
                        i_next = MW'(1);
                        state_next = (m_eff == MW'(1)) ? S_D_RD0 : S_P_RD;
                    end else begin
                        load_count_next = load_count_reg + CW'(1);
                    end
                end
            end
            S_P_RD:
            begin
                mem_raddr = idx(k_reg, k_reg, m_eff);
                state_next = S_S_RD;
            end
            S_S_RD:
            begin
                mem_raddr = idx(i_reg, k_reg, m_eff);
                piv_next = rdata_reg;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                fpu_req.start = 1'b1;
                fpu_req.op = lud_pkg::FP_DIV;
                fpu_req.a = rdata_reg;
                fpu_req.b = piv_reg;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (fpu_rsp.done) begin
                    l_next = fpu_rsp.result;
                    j_next = k_reg + MW'(1);
                    state_next = S_K_RD;
                end
            end
            S_K_RD:
            begin
                mem_raddr = idx(k_reg, j_reg, m_eff);
                state_next = S_I_RD;
            end
            S_I_RD:
            begin
                mem_raddr = idx(i_reg, j_reg, m_eff);
                ukj_next = rdata_reg;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                uij_next = rdata_reg;
                fpu_req.start = 1'b1;
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (fpu_rsp.done) begin
                    fpu_req.start = 1'b1;
                    fpu_req.op = lud_pkg::FP_SUB;
                    fpu_req.a = uij_reg;
                    fpu_req.b = fpu_rsp.result;
                    state_next = S_SUB_WAIT;
                end
            end
            S_SUB_WAIT:
            begin
                if (fpu_rsp.done) begin
                    mem_we = 1'b1;
                    mem_waddr = idx(i_reg, j_reg, m_eff);
                    mem_wdata = fpu_rsp.result;
                    if (j_reg + MW'(1) < m_eff) begin
                        j_next = j_reg + MW'(1);
                        state_next = S_K_RD;
                    end else if (i_reg + MW'(1) < m_eff) begin
                        i_next = i_reg + MW'(1);
                        state_next = S_P_RD;
                    end else if (k_reg + MW'(2) < m_eff) begin
                        k_next = k_reg + MW'(1);
                        i_next = k_reg + MW'(2);
                        state_next = S_P_RD;
                    end else begin
                        state_next = S_D_RD0;
                    end
                end
            end
            S_D_RD0:
            begin
                mem_raddr = '0;
                state_next = S_D_FIRST;
            end
            S_D_FIRST:
            begin
                det_next = rdata_reg;
                i_next = MW'(1);
                state_next = (m_eff == MW'(1)) ? S_OUT : S_D_RD;
            end
            S_D_RD:
            begin
                mem_raddr = idx(i_reg, i_reg, m_eff);
                state_next = S_D_MUL;
            end
            S_D_MUL:
            begin
                fpu_req.start = 1'b1;
                fpu_req.a = det_reg;
                fpu_req.b = rdata_reg;
                state_next = S_D_WAIT;
            end
            S_D_WAIT:
            begin
                if (fpu_rsp.done) begin
                    det_next = fpu_rsp.result;
                    if (i_reg + MW'(1) < m_eff) begin
                        i_next = i_reg + MW'(1);
                        state_next = S_D_RD;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg) begin
                    out_valid_next = 1'b1;
                    det_out_next = lud_pkg::fp_is_nan(det_reg) ? lud_pkg::CANON_NAN : det_reg;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // Any size write restarts the load
        if (cfg_wr && (paddr[2] == lud_pkg::REG_MATRIX_SIZE)) begin
            matrix_size_next = pwdata[3:0];
            load_count_next = '0;
        end
    end

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_LOAD;
            matrix_size_reg <= lud_pkg::MATRIX_SIZE_RESET;
            load_count_reg <= '0;
            k_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            out_valid_reg <= 1'b0;
            det_out_reg <= '0;
        end else begin
            state_reg <= state_next;
            matrix_size_reg <= matrix_size_next;
            load_count_reg <= load_count_next;
            k_reg <= k_next;
            i_reg <= i_next;
            j_reg <= j_next;
            out_valid_reg <= out_valid_next;
            det_out_reg <= det_out_next;
        end
    end

    // Operand holding registers
    always_ff @(posedge clk)
    begin
        piv_reg <= piv_next;
        l_reg <= l_next;
        ukj_reg <= ukj_next;
        uij_reg <= uij_next;
        det_reg <= det_next;
    end

    // Matrix memory with one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // The shared unit is only started when it is free
    a_fpu_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fpu_req.start |-> fpu_rsp.idle)
        else $error("fpu started while busy");

    // Load counter stays inside the current matrix
    a_load_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (load_count_reg < total))
        else $error("load count out of range");

    // Results only come back while the sequencer waits for one
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        fpu_rsp.done |-> (state_reg == S_DIV_WAIT || state_reg == S_MUL_WAIT ||
                          state_reg == S_SUB_WAIT || state_reg == S_D_WAIT))
        else $error("unexpected fpu result");

endmodule
